// ----- rtl/core/stbs_pkg.sv -----
`default_nettype none

package stbs_pkg;

    // Table geometry. Bound registers must hold the table depth itself.
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BOUND_W     = $clog2(TABLE_DEPTH + 1);

    // Field widths fixed by the interface.
    localparam int CMD_W      = 1;
    localparam int ENTRY_IX_W = 4;
    localparam int VALUE_W    = 8;
    localparam int KEY_W      = 8;
    localparam int SIZE_W     = 5;
    localparam int POS_W      = 4;

    localparam int S_TDATA_BITS = ENTRY_IX_W + VALUE_W + KEY_W;
    localparam int S_TDATA_W    = ((S_TDATA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((POS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_entry;
        logic start_search;
        logic probe_step;
        logic load_result;
    } stbs_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic range_empty;
        logic out_free;
    } stbs_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/stbs_ctrl.sv -----
`default_nettype none

module stbs_ctrl
    import stbs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    input  wire cmd_t      s_cmd,
    output logic           s_tready,
    input  wire stbs_sts_t sts,
    output stbs_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_PROBE = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        cmd              = '0;
        s_tready         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_cmd == CMD_SEARCH) begin
                        cmd.start_search = 1'b1;
                        state_next       = ST_PROBE;
                    end else begin
                        cmd.write_entry = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                if (sts.range_empty) begin
                    // Hold the finished search until the output register frees up.
                    if (sts.out_free) begin
                        cmd.load_result = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    cmd.probe_step = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/stbs_dpath.sv -----
`default_nettype none

module stbs_dpath
    import stbs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [SIZE_W-1:0]     cfg_wr_data,
    input  wire logic [ENTRY_IX_W-1:0] entry_index,
    input  wire logic [VALUE_W-1:0]    entry_value,
    input  wire logic [KEY_W-1:0]      search_key,
    input  wire stbs_cmd_t             cmd,
    output stbs_sts_t                  sts,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic                       m_found,
    output logic [POS_W-1:0]           m_position
);

    logic [VALUE_W-1:0] table_mem [TABLE_DEPTH];

    logic [SIZE_W-1:0]  size_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [BOUND_W-1:0] low_reg,  low_next;
    logic [BOUND_W-1:0] high_reg, high_next;
    logic               seen_reg, seen_next;
    logic [POS_W-1:0]   pos_reg,  pos_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic [VALUE_W-1:0] probe_value_reg;

    logic [BOUND_W:0]   bound_sum;
    logic [BOUND_W-1:0] mid;
    logic [BOUND_W:0]   next_sum;
    logic [BOUND_W-1:0] next_mid;
    logic [BOUND_W-1:0] limit;
    logic               wr_in_range;

    assign bound_sum   = {1'b0, low_reg} + {1'b0, high_reg};
    assign mid         = bound_sum[BOUND_W:1];
    // The table is read at the middle of the next bounds and registered, so the
    // registered entry always matches the current middle.
    assign next_sum    = {1'b0, low_next} + {1'b0, high_next};
    assign next_mid    = next_sum[BOUND_W:1];
    assign wr_in_range = 32'(entry_index) < 32'(TABLE_DEPTH);
    assign limit       = (32'(size_reg) > 32'(TABLE_DEPTH)) ? BOUND_W'(TABLE_DEPTH)
                                                            : BOUND_W'(size_reg);

    assign sts.range_empty = (low_reg == high_reg);
    assign sts.out_free    = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.write_entry && wr_in_range) begin
            table_mem[IDX_W'(entry_index)] <= entry_value;
        end
        probe_value_reg <= table_mem[IDX_W'(next_mid)];
    end

    always_comb begin
        low_next  = low_reg;
        high_next = high_reg;
        seen_next = seen_reg;
        pos_next  = pos_reg;
        if (cmd.start_search) begin
            low_next  = '0;
            high_next = limit;
            seen_next = 1'b0;
            pos_next  = '0;
        end else if (cmd.probe_step) begin
            if (probe_value_reg == key_reg) begin
                seen_next = 1'b1;
                pos_next  = POS_W'(mid);
            end
            if (probe_value_reg < key_reg) begin
                low_next = mid + BOUND_W'(1);
            end else begin
                high_next = mid;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_result) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            seen_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
            end
            low_reg       <= low_next;
            high_reg      <= high_next;
            seen_reg      <= seen_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_search) begin
            key_reg <= search_key;
        end
        if (cmd.load_result) begin
            out_found_reg <= seen_reg;
            out_pos_reg   <= seen_reg ? pos_reg : '0;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_found    = out_found_reg;
    assign m_position = out_pos_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sorted_table_binary_search.sv -----
// Sorted table with leftmost-match binary search.
// The input stream (s_*) carries commands. s_tuser selects the kind: a write
// stores entry_value at entry_index and produces no result; a search looks for
// search_key among the first table_size entries and produces one result on the
// output stream (m_*): m_tuser is the found flag, m_tdata the lowest matching
// index, which reads 0 when nothing matched. The table must be sorted ascending.
// table_size is written through cfg_wr_en/cfg_wr_data by the user, who must do
// so only while the block is idle; the block itself does not enforce this. A
// write is stored without leaving idle, so writes can be taken back to back. A
// search occupies the block for the transfer, the probes of the single table
// read port (at most 5 for a 16 entry table, about log2 of table_size plus one),
// and the output register load. The result appears the cycle after that load.
// The output register decouples the two sides: a new command is accepted while
// an earlier result still waits. If the receiver stalls, a finished search
// waits in its final cycle until the output register frees, and no new input is
// taken meanwhile. Reset (aresetn low, synchronous) clears table_size, the
// search state and the output valid; table contents stay undefined until written.
`default_nettype none

module sorted_table_binary_search
    import stbs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration: table_size.
    input  wire logic                 cfg_wr_en,
    input  wire logic [SIZE_W-1:0]    cfg_wr_data,
    // Command stream.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // entry_index[3:0], entry_value[11:4],
                                                // search_key[19:12], zero fill above
    input  wire logic [CMD_W-1:0]     s_tuser,  // command[0]
    // Result stream.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,  // position[3:0], zero fill above
    output logic [0:0]                m_tuser   // found[0]
);

    stbs_cmd_t        cmd;
    stbs_sts_t        sts;
    logic             found;
    logic [POS_W-1:0] position;

    // The controller sequences writes, probes and the result load.
    stbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_cmd    (cmd_t'(s_tuser)),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the table, the bisection bounds and the output register.
    stbs_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .entry_index (s_tdata[ENTRY_IX_W-1:0]),
        .entry_value (s_tdata[ENTRY_IX_W+VALUE_W-1:ENTRY_IX_W]),
        .search_key  (s_tdata[ENTRY_IX_W+VALUE_W+KEY_W-1:ENTRY_IX_W+VALUE_W]),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_found     (found),
        .m_position  (position)
    );

    assign m_tdata = M_TDATA_W'(position);
    assign m_tuser = found;

`ifndef SYNTHESIS
    // A search transfer makes the block busy in the following cycle.
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == CMD_SEARCH) |=> !s_tready)
        else $error("search accepted but block not busy afterwards");

    // A new result can only come from a search in progress.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a search in progress");

    // A miss always reports position zero.
    a_miss_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("miss reported with nonzero position");
`endif

endmodule

`default_nettype wire
